[rtl/core/sars_pkg.sv]
// ----------------------------------------------------------------------------
// sars_pkg
// Shared types and codes of the segmented array range sum block.
// ----------------------------------------------------------------------------
package sars_pkg;

  localparam int CFG_INDEX_W = 1;

  localparam logic [1:0] CMD_WRITE_SLOT = 2'd0;
  localparam logic [1:0] CMD_WRITE_SIZE = 2'd1;
  localparam logic [1:0] CMD_QUERY      = 2'd2;
  localparam logic [1:0] CMD_UNUSED     = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] REG_SEGMENTS_IN_USE  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_SEGMENT_CAPACITY = 1'b1;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_WRITE_SLOT,
    OP_WRITE_SIZE,
    OP_LOAD_QUERY,
    OP_CLAMP,
    OP_SIZE_RD_SEG,
    OP_UP_BOUNDS,
    OP_KEY_RD_P,
    OP_UP_NEXT_SEG,
    OP_UP_NEXT_SLOT,
    OP_UP_HIT,
    OP_UP_RUNEND,
    OP_SIZE_RD_S,
    OP_DN_BOUNDS,
    OP_KEY_RD_Q,
    OP_DN_PREV_SEG,
    OP_DN_PREV_SLOT,
    OP_DN_HIT,
    OP_SUM_ACC,
    OP_SUM_STEP,
    OP_SUM_SL,
    OP_SUM_SR,
    OP_OUT_FOUND,
    OP_OUT_EMPTY
  } dp_op_t;

  typedef struct packed {
    logic query_empty;
    logic seg_out;
    logic up_done;
    logic key_lt_lo;
    logic key_gt_hi;
    logic last_lt_seg;
    logic seg_even;
    logic dn_done;
    logic s_is_seg;
    logic q_le_pos;
    logic sum_more;
    logic step_out;
    logic p_ge_end;
  } dp_status_t;

endpackage

[rtl/core/sars_dp.sv]
// ----------------------------------------------------------------------------
// sars_dp
// Datapath: slot and segment-count memories, query registers, bound
// arithmetic and the key and value accumulators.
// ----------------------------------------------------------------------------
module sars_dp #(
  parameter int MAX_SEGMENTS      = 64,
  parameter int MAX_SEGMENT_SLOTS = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  sars_pkg::dp_op_t                 op,
  output sars_pkg::dp_status_t             status,
  input  logic                             cfg_we,
  input  logic [sars_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [6:0]                       cfg_data,
  input  logic [11:0]                      slot_index,
  input  logic signed [63:0]               slot_key,
  input  logic signed [63:0]               slot_value,
  input  logic [5:0]                       size_segment,
  input  logic [6:0]                       size_count,
  input  logic [5:0]                       first_segment,
  input  logic [5:0]                       last_segment,
  input  logic signed [63:0]               low_key,
  input  logic signed [63:0]               high_key,
  output logic                             found,
  output logic signed [63:0]               first_key,
  output logic signed [63:0]               last_key,
  output logic [12:0]                      element_count,
  output logic signed [63:0]               key_sum,
  output logic signed [63:0]               value_sum
);
  import sars_pkg::*;

  localparam int TOTAL  = MAX_SEGMENTS * MAX_SEGMENT_SLOTS;
  localparam int ADDR_W = $clog2(TOTAL);
  localparam int POS_W  = $clog2(TOTAL + 1);
  localparam int SEG_W  = $clog2(MAX_SEGMENTS);
  localparam int SEGX_W = ($clog2(MAX_SEGMENTS + 2) > 7) ? $clog2(MAX_SEGMENTS + 2) : 7;
  localparam int CAP_W  = $clog2(MAX_SEGMENT_SLOTS + 1);

  logic [6:0] reg_segments;
  logic [6:0] reg_capacity;
  logic [SEGX_W-1:0] nseg;
  logic [CAP_W-1:0]  cap;

  logic [63:0] key_mem [TOTAL];
  logic [63:0] val_mem [TOTAL];
  logic [6:0]  cnt_mem [MAX_SEGMENTS];
  logic [MAX_SEGMENTS-1:0] cnt_valid;

  logic signed [63:0] kdata;
  logic signed [63:0] vdata;
  logic [6:0]         cdata;
  logic               cvld;
  logic [SEGX_W-1:0]  rseg;

  logic [SEGX_W-1:0] first_q, last_q, seg, s;
  logic signed [63:0] lo_q, hi_q;
  logic signed [63:0] fkey, lkey;
  logic [POS_W-1:0] p, q, a, b, pos, runend, endp, stop;
  logic [CAP_W-1:0] sl;
  logic [12:0] count;
  logic [63:0] ksum, vsum;

  logic              slot_ok, size_ok;
  logic [ADDR_W-1:0] slot_addr, kaddr;
  logic [SEG_W-1:0]  size_addr, cidx;
  logic [SEGX_W-1:0] cseg, mul_seg, s_step;
  logic [SEGX_W+CAP_W-1:0] prod;
  logic [POS_W-1:0] base, sz_p, lo_b, hi_b, sr_end;
  logic [CAP_W-1:0] cnt_cl, sz;
  logic bnd_even, key_rd, cnt_rd;

  assign nseg = (32'(reg_segments) > MAX_SEGMENTS) ? SEGX_W'(MAX_SEGMENTS)
                                                   : SEGX_W'(reg_segments);
  assign cap = (32'(reg_capacity) > MAX_SEGMENT_SLOTS) ? CAP_W'(MAX_SEGMENT_SLOTS)
                                                       : CAP_W'(reg_capacity);

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_segments <= 7'd64;
      reg_capacity <= 7'd64;
    end else if (cfg_we) begin
      if (cfg_index == REG_SEGMENTS_IN_USE) begin
        reg_segments <= cfg_data;
      end else begin
        reg_capacity <= cfg_data;
      end
    end
  end

  assign slot_ok   = 32'(slot_index) < TOTAL;
  assign slot_addr = ADDR_W'(slot_index);
  assign size_ok   = 32'(size_segment) < MAX_SEGMENTS;
  assign size_addr = SEG_W'(size_segment);
  assign key_rd    = (op == OP_KEY_RD_P) || (op == OP_KEY_RD_Q);
  assign kaddr     = ADDR_W'((op == OP_KEY_RD_Q) ? q - 1'b1 : p);
  assign s_step    = s + (s[0] ? SEGX_W'(1) : SEGX_W'(2));

  always_comb begin
    cnt_rd = 1'b1;
    unique case (op)
      OP_SIZE_RD_SEG: cseg = seg;
      OP_UP_HIT:      cseg = seg + 1'b1;
      OP_SIZE_RD_S:   cseg = s;
      OP_SUM_STEP:    cseg = s_step;
      OP_SUM_SL:      cseg = s + 1'b1;
      default: begin
        cseg   = seg;
        cnt_rd = 1'b0;
      end
    endcase
  end
  assign cidx = SEG_W'(cseg);

  always_ff @(posedge clk) begin
    if (op == OP_WRITE_SLOT && slot_ok) begin
      key_mem[slot_addr] <= slot_key;
      val_mem[slot_addr] <= slot_value;
    end
    if (key_rd) begin
      kdata <= key_mem[kaddr];
      vdata <= val_mem[kaddr];
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_WRITE_SIZE && size_ok) begin
      cnt_mem[size_addr] <= size_count;
    end
    if (cnt_rd) begin
      cdata <= cnt_mem[cidx];
      cvld  <= cnt_valid[cidx] && (32'(cseg) < MAX_SEGMENTS);
      rseg  <= cseg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_valid <= '0;
    end else if (op == OP_WRITE_SIZE && size_ok) begin
      cnt_valid[size_addr] <= 1'b1;
    end
  end

  assign cnt_cl = (32'(cdata) > 32'(cap)) ? cap : CAP_W'(cdata);
  assign sz     = (cvld && rseg < nseg) ? cnt_cl : '0;
  assign sz_p   = POS_W'(sz);

  always_comb begin
    unique case (op)
      OP_UP_BOUNDS: mul_seg = seg + SEGX_W'(!seg[0]);
      OP_DN_BOUNDS: mul_seg = s + SEGX_W'(!s[0]);
      OP_UP_RUNEND: mul_seg = seg + 1'b1;
      OP_SUM_SL:    mul_seg = s + 1'b1;
      default:      mul_seg = seg;
    endcase
  end

  assign prod     = mul_seg * cap;
  assign base     = POS_W'(prod);
  assign bnd_even = (op == OP_DN_BOUNDS) ? !s[0] : !seg[0];
  assign lo_b     = bnd_even ? base - sz_p : base;
  assign hi_b     = bnd_even ? base : base + sz_p;
  assign sr_end   = p + POS_W'(sl) + sz_p;

  always_ff @(posedge clk) begin
    unique case (op)
      OP_LOAD_QUERY: begin
        first_q <= SEGX_W'(first_segment);
        last_q  <= SEGX_W'(last_segment);
        lo_q    <= low_key;
        hi_q    <= high_key;
      end
      OP_CLAMP: begin
        if (last_q >= nseg) begin
          last_q <= nseg - 1'b1;
        end
        seg <= first_q;
      end
      OP_UP_BOUNDS: begin
        a <= lo_b;
        b <= hi_b;
        p <= lo_b;
      end
      OP_UP_NEXT_SEG:  seg <= seg + 1'b1;
      OP_UP_NEXT_SLOT: p <= p + 1'b1;
      OP_UP_HIT: begin
        pos    <= p;
        fkey   <= kdata;
        runend <= b;
        s      <= last_q;
      end
      OP_UP_RUNEND: runend <= base + sz_p;
      OP_DN_BOUNDS: begin
        a <= lo_b;
        b <= hi_b;
        q <= hi_b;
      end
      OP_DN_PREV_SEG:  s <= s - 1'b1;
      OP_DN_PREV_SLOT: q <= q - 1'b1;
      OP_DN_HIT: begin
        endp  <= q;
        lkey  <= kdata;
        p     <= pos;
        stop  <= (runend < q) ? runend : q;
        s     <= seg;
        count <= '0;
        ksum  <= '0;
        vsum  <= '0;
      end
      OP_SUM_ACC: begin
        ksum  <= ksum + kdata;
        vsum  <= vsum + vdata;
        count <= count + 13'd1;
        p     <= p + 1'b1;
      end
      OP_SUM_STEP: s <= s_step;
      OP_SUM_SL: begin
        sl <= sz;
        p  <= base - sz_p;
      end
      OP_SUM_SR: stop <= (sr_end < endp) ? sr_end : endp;
      OP_OUT_FOUND: begin
        found         <= 1'b1;
        first_key     <= fkey;
        last_key      <= lkey;
        element_count <= count;
        key_sum       <= ksum;
        value_sum     <= vsum;
      end
      OP_OUT_EMPTY: begin
        found         <= 1'b0;
        first_key     <= '0;
        last_key      <= '0;
        element_count <= '0;
        key_sum       <= '0;
        value_sum     <= '0;
      end
      default: begin
      end
    endcase
  end

  assign status.query_empty = (hi_q < lo_q) || (last_q < first_q) || (nseg == '0);
  assign status.seg_out     = seg >= nseg;
  assign status.up_done     = p >= b;
  assign status.key_lt_lo   = kdata < lo_q;
  assign status.key_gt_hi   = kdata > hi_q;
  assign status.last_lt_seg = last_q < seg;
  assign status.seg_even    = !seg[0];
  assign status.dn_done     = q <= a;
  assign status.s_is_seg    = s == seg;
  assign status.q_le_pos    = q <= pos;
  assign status.sum_more    = p < stop;
  assign status.step_out    = s_step >= nseg;
  assign status.p_ge_end    = p >= endp;

  a_sum_inside: assert property (@(posedge clk) disable iff (rst)
    op == OP_SUM_ACC |-> p < endp)
    else $error("summed slot lies beyond the end of the range");

  a_down_read: assert property (@(posedge clk) disable iff (rst)
    op == OP_KEY_RD_Q |-> q > a)
    else $error("downward read below the segment's first element");

endmodule

[rtl/core/sars_ctrl.sv]
// ----------------------------------------------------------------------------
// sars_ctrl
// Controller: sequences writes and the query phases (upward search, downward
// search, summing walk) and owns the result handshake.
// ----------------------------------------------------------------------------
module sars_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           cmd,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  sars_pkg::dp_status_t status,
  output sars_pkg::dp_op_t     op
);
  import sars_pkg::*;

  typedef enum logic [16:0] {
    ST_IDLE    = 17'd1,
    ST_START   = 17'd2,
    ST_UP_SEG  = 17'd4,
    ST_UP_SIZE = 17'd8,
    ST_UP_RD   = 17'd16,
    ST_UP_CMP  = 17'd32,
    ST_UP_RUN  = 17'd64,
    ST_DN_SEG  = 17'd128,
    ST_DN_SIZE = 17'd256,
    ST_DN_RD   = 17'd512,
    ST_DN_CMP  = 17'd1024,
    ST_SUM_RD  = 17'd2048,
    ST_SUM_ACC = 17'd4096,
    ST_SUM_SL  = 17'd8192,
    ST_SUM_SR  = 17'd16384,
    ST_DONE    = 17'd32768,
    ST_EMPTY   = 17'd65536
  } state_t;

  state_t state, state_next;
  logic   out_busy;

  assign in_stall = state != ST_IDLE;
  assign out_busy = out_valid && out_stall;

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (cmd)
            CMD_WRITE_SLOT: op = OP_WRITE_SLOT;
            CMD_WRITE_SIZE: op = OP_WRITE_SIZE;
            CMD_QUERY: begin
              op         = OP_LOAD_QUERY;
              state_next = ST_START;
            end
            default: begin
            end
          endcase
        end
      end
      ST_START: begin
        if (status.query_empty) begin
          state_next = ST_EMPTY;
        end else begin
          op         = OP_CLAMP;
          state_next = ST_UP_SEG;
        end
      end
      ST_UP_SEG: begin
        if (status.seg_out) begin
          state_next = ST_EMPTY;
        end else begin
          op         = OP_SIZE_RD_SEG;
          state_next = ST_UP_SIZE;
        end
      end
      ST_UP_SIZE: begin
        op         = OP_UP_BOUNDS;
        state_next = ST_UP_RD;
      end
      ST_UP_RD: begin
        if (status.up_done) begin
          op         = OP_UP_NEXT_SEG;
          state_next = ST_UP_SEG;
        end else begin
          op         = OP_KEY_RD_P;
          state_next = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        priority if (status.key_lt_lo) begin
          op         = OP_UP_NEXT_SLOT;
          state_next = ST_UP_RD;
        end else if (status.key_gt_hi || status.last_lt_seg) begin
          state_next = ST_EMPTY;
        end else begin
          op         = OP_UP_HIT;
          state_next = status.seg_even ? ST_UP_RUN : ST_DN_SEG;
        end
      end
      ST_UP_RUN: begin
        op         = OP_UP_RUNEND;
        state_next = ST_DN_SEG;
      end
      ST_DN_SEG: begin
        op         = OP_SIZE_RD_S;
        state_next = ST_DN_SIZE;
      end
      ST_DN_SIZE: begin
        op         = OP_DN_BOUNDS;
        state_next = ST_DN_RD;
      end
      ST_DN_RD: begin
        priority if (status.dn_done && status.s_is_seg) begin
          state_next = ST_EMPTY;
        end else if (status.dn_done) begin
          op         = OP_DN_PREV_SEG;
          state_next = ST_DN_SEG;
        end else begin
          op         = OP_KEY_RD_Q;
          state_next = ST_DN_CMP;
        end
      end
      ST_DN_CMP: begin
        priority if (status.key_gt_hi) begin
          op         = OP_DN_PREV_SLOT;
          state_next = ST_DN_RD;
        end else if (status.q_le_pos) begin
          state_next = ST_EMPTY;
        end else begin
          op         = OP_DN_HIT;
          state_next = ST_SUM_RD;
        end
      end
      ST_SUM_RD: begin
        if (status.sum_more) begin
          op         = OP_KEY_RD_P;
          state_next = ST_SUM_ACC;
        end else begin
          op         = OP_SUM_STEP;
          state_next = status.step_out ? ST_DONE : ST_SUM_SL;
        end
      end
      ST_SUM_ACC: begin
        op         = OP_SUM_ACC;
        state_next = ST_SUM_RD;
      end
      ST_SUM_SL: begin
        op         = OP_SUM_SL;
        state_next = ST_SUM_SR;
      end
      ST_SUM_SR: begin
        op         = OP_SUM_SR;
        state_next = status.p_ge_end ? ST_DONE : ST_SUM_RD;
      end
      ST_DONE: begin
        if (!out_busy) begin
          op         = OP_OUT_FOUND;
          state_next = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (!out_busy) begin
          op         = OP_OUT_EMPTY;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (op == OP_OUT_FOUND || op == OP_OUT_EMPTY) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (op == OP_OUT_FOUND || op == OP_OUT_EMPTY) |-> !out_busy)
    else $error("result loaded over one still waiting");

  a_query_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && cmd == CMD_QUERY) |=> state == ST_START)
    else $error("accepted query did not start");

endmodule

[rtl/core/segmented_array_range_sum.sv]
// ----------------------------------------------------------------------------
// segmented_array_range_sum
// A query walks the segments and slots one read at a time through the single
// read port of the slot memories. One item is handled at a time and results
// leave through an output register.
// Synchronous reset empties the store (segment counts) and sets both
// registers to 64; slot contents are undefined until written.
// ----------------------------------------------------------------------------
module segmented_array_range_sum #(
  parameter int MAX_SEGMENTS      = 64,
  parameter int MAX_SEGMENT_SLOTS = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sars_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [6:0]                       cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       cmd,
  input  logic [11:0]                      slot_index,
  input  logic signed [63:0]               slot_key,
  input  logic signed [63:0]               slot_value,
  input  logic [5:0]                       size_segment,
  input  logic [6:0]                       size_count,
  input  logic [5:0]                       first_segment,
  input  logic [5:0]                       last_segment,
  input  logic signed [63:0]               low_key,
  input  logic signed [63:0]               high_key,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             found,
  output logic signed [63:0]               first_key,
  output logic signed [63:0]               last_key,
  output logic [12:0]                      element_count,
  output logic signed [63:0]               key_sum,
  output logic signed [63:0]               value_sum
);
  import sars_pkg::*;

  dp_op_t     op;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  sars_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .op       (op)
  );

  sars_dp #(
    .MAX_SEGMENTS     (MAX_SEGMENTS),
    .MAX_SEGMENT_SLOTS(MAX_SEGMENT_SLOTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .status       (status),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .slot_index   (slot_index),
    .slot_key     (slot_key),
    .slot_value   (slot_value),
    .size_segment (size_segment),
    .size_count   (size_count),
    .first_segment(first_segment),
    .last_segment (last_segment),
    .low_key      (low_key),
    .high_key     (high_key),
    .found        (found),
    .first_key    (first_key),
    .last_key     (last_key),
    .element_count(element_count),
    .key_sum      (key_sum),
    .value_sum    (value_sum)
  );

endmodule
